>>> sv/nat_flow_translation_table_defines.svh
// Assertion macros used by the translation table back end.
`ifndef NAT_FLOW_TRANSLATION_TABLE_DEFINES_SVH
`define NAT_FLOW_TRANSLATION_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NFTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NFTT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define NFTT_ASSERT(lbl, prop, msg)
`define NFTT_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/nftt_pkg.sv
// Types and constants of the flow translation table.
package nftt_pkg;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [15:0] FirstPortRst = 16'd1024;

  typedef enum logic [0:0] {
    CFG_PUBLIC_IP  = 1'b0,
    CFG_FIRST_PORT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OP_OUTBOUND = 1'b0,
    OP_INBOUND  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NO_MATCH = 2'd2
  } status_e;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [31:0] src_ip;
    logic [15:0] sport;
    logic [31:0] dst_ip;
    logic [15:0] dport;
    logic [7:0]  proto;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_ip;
    logic [15:0] out_port;
  } out_item_t;

  typedef struct packed {
    logic [31:0] int_ip;
    logic [15:0] int_port;
    logic [31:0] rem_ip;
    logic [15:0] rem_port;
    logic [7:0]  proto;
    logic [15:0] ext_port;
  } flow_entry_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } queue_head_t;
endpackage

>>> sv/nftt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module nftt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/nftt_front.sv
// Front end: accepts headers into a two-entry queue for the lookup engine.
module nftt_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  nftt_pkg::in_item_t    in_data_i,
  input  logic                  pop_i,
  output nftt_pkg::queue_head_t head_o
);
  import nftt_pkg::*;

  in_item_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item = slot_q[rd_ptr_q];
endmodule

>>> sv/nftt_back.sv
// Back end: scans the flow table, appends new flows and drives the result register.
`include "nat_flow_translation_table_defines.svh"
module nftt_back #(
  parameter int unsigned TableDepth = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nftt_pkg::queue_head_t head_i,
  output logic                  pop_o,
  input  logic                  clear_i,
  input  logic [31:0]           public_ip_i,
  input  logic [15:0]           first_port_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nftt_pkg::out_item_t   out_data_o
);
  import nftt_pkg::*;

  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam int unsigned AddrW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned EntryW = $bits(flow_entry_t);
  localparam logic [CntW-1:0] Full = CntW'(TableDepth);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_RES  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d, count_q, count_d;
  logic [15:0]     port_cnt_q, port_cnt_d;
  logic            hit_q, hit_d;
  logic [31:0]     hit_ip_q, hit_ip_d;
  logic [15:0]     hit_port_q, hit_port_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_data_q, out_data_d;
  flow_entry_t     rd_entry, new_entry;
  logic [EntryW-1:0] rdata;
  logic            we, match, out_free;
  in_item_t        it;

  assign it = head_i.item;
  assign rd_entry = flow_entry_t'(rdata);
  assign out_free = !out_valid_q || !out_stall_i;

  assign new_entry.int_ip = it.src_ip;
  assign new_entry.int_port = it.sport;
  assign new_entry.rem_ip = it.dst_ip;
  assign new_entry.rem_port = it.dport;
  assign new_entry.proto = it.proto;
  assign new_entry.ext_port = port_cnt_q;

  always_comb begin
    if (it.opcode == OP_OUTBOUND) begin
      match = rd_entry.int_ip == it.src_ip && rd_entry.int_port == it.sport &&
              rd_entry.rem_ip == it.dst_ip && rd_entry.rem_port == it.dport &&
              rd_entry.proto == it.proto;
    end else begin
      match = rd_entry.ext_port == it.dport && rd_entry.rem_ip == it.src_ip &&
              rd_entry.rem_port == it.sport && rd_entry.proto == it.proto;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    count_d = count_q;
    port_cnt_d = port_cnt_q;
    hit_d = hit_q;
    hit_ip_d = hit_ip_q;
    hit_port_d = hit_port_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d = out_data_q;
    we = 1'b0;
    pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idx_d = '0;
        hit_d = 1'b0;
        if (head_i.valid) begin
          state_d = (count_q == '0) ? S_RES : S_RD;
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (match) begin
          hit_d = 1'b1;
          hit_ip_d = (it.opcode == OP_OUTBOUND) ? public_ip_i : rd_entry.int_ip;
          hit_port_d = (it.opcode == OP_OUTBOUND) ? rd_entry.ext_port : rd_entry.int_port;
          state_d = S_RES;
        end else if (idx_q + CntW'(1) == count_q) begin
          state_d = S_RES;
        end else begin
          idx_d = idx_q + CntW'(1);
          state_d = S_RD;
        end
      end
      S_RES: begin
        if (out_free) begin
          pop_o = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
          if (hit_q) begin
            out_data_d = '{status: ST_OK, out_ip: hit_ip_q, out_port: hit_port_q};
          end else if (it.opcode == OP_INBOUND) begin
            out_data_d = '{status: ST_NO_MATCH, out_ip: 32'd0, out_port: 16'd0};
          end else if (count_q == Full) begin
            out_data_d = '{status: ST_FULL, out_ip: 32'd0, out_port: 16'd0};
          end else begin
            we = 1'b1;
            count_d = count_q + CntW'(1);
            port_cnt_d = port_cnt_q + 16'd1;
            out_data_d = '{status: ST_OK, out_ip: public_ip_i, out_port: port_cnt_q};
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (clear_i) begin
      count_d = '0;
      port_cnt_d = first_port_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q <= '0;
      count_q <= '0;
      port_cnt_q <= FirstPortRst;
      hit_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      count_q <= count_d;
      port_cnt_q <= port_cnt_d;
      hit_q <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_ip_q <= hit_ip_d;
    hit_port_q <= hit_port_d;
    out_data_q <= out_data_d;
  end

  nftt_ram #(
    .Width(EntryW),
    .Depth(TableDepth),
    .AddrW(AddrW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(new_entry),
    .raddr_i(idx_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  `NFTT_ASSERT(a_count_bound, count_q <= Full, "flow count above table depth")
  `NFTT_ASSERT(a_read_in_range, state_q == S_RD |-> idx_q < count_q, "scan past last flow")
  `NFTT_ASSERT(a_pop_on_result, pop_o |-> state_q == S_RES && head_i.valid, "early pop")
  `NFTT_NEVER(a_write_full, we && count_q == Full, "append into a full table")
endmodule

>>> sv/nat_flow_translation_table.sv
// Top level of the NAT flow translation table.
// Each header is accepted into a two-entry queue and then looked up by a scan of the flow
// table through its single read port, with a read state and a compare state for each flow in
// use (up to TABLE_DEPTH) until a match; the result then waits for the result register to be
// free. A write to either configuration register empties the table and reloads the port
// counter at once; there is no clearing pass after reset.
module nat_flow_translation_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  nftt_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output nftt_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [nftt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nftt_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import nftt_pkg::*;

  logic [31:0]  public_ip_q;
  logic [15:0]  first_port_q;
  queue_head_t  head;
  logic         pop;
  logic [15:0]  first_port;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      public_ip_q <= 32'd0;
      first_port_q <= FirstPortRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_PUBLIC_IP:  public_ip_q <= cfg_wdata_i;
        CFG_FIRST_PORT: first_port_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // The counter reload takes the value being written to first_port in the same transfer.
  assign first_port = (cfg_we_i && cfg_idx_e'(cfg_idx_i) == CFG_FIRST_PORT) ?
                      cfg_wdata_i[15:0] : first_port_q;

  nftt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .pop_i     (pop),
    .head_o    (head)
  );

  nftt_back #(
    .TableDepth(TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .clear_i     (cfg_we_i),
    .public_ip_i (public_ip_q),
    .first_port_i(first_port),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule
